// ===== sv/rtc_to_unix_timekeeper_top_assert.svh =====
// Assertion macros for the RTC to Unix timekeeper.
`ifndef RTC_TO_UNIX_TIMEKEEPER_TOP_ASSERT_SVH
`define RTC_TO_UNIX_TIMEKEEPER_TOP_ASSERT_SVH

`ifndef SYNTH
`define RTUT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rtut assertion failed");
`define RTUT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rtut assertion failed");
`else
`define RTUT_ASSERT_IMPL(label, ante, cons)
`define RTUT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== sv/rtut_pkg.sv =====
// Types, constants and helper functions shared by the timekeeper modules.
`default_nettype none

package rtut_pkg;

    typedef struct packed {
        logic       cmd;
        logic       read_ok;
        logic [7:0] raw_seconds;
        logic [7:0] raw_minutes;
        logic [7:0] raw_hours;
        logic [7:0] raw_day;
        logic [7:0] raw_month;
        logic [7:0] raw_year;
        logic [7:0] rtc_status;
    } t_in;

    typedef struct packed {
        logic [31:0] unix_seconds;
        logic [31:0] uptime;
        logic        load_valid;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_DECODE,
        S_YEAR,
        S_DAYS,
        S_MUL,
        S_SUM,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic capture;
        logic tick;
        logic decode;
        logic year_step;
        logic add_days;
        logic mul;
        logic sum;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic is_load;
        logic ok;
        logic year_done;
    } t_stat;

    localparam int unsigned SB_BINARY_BIT = 2;
    localparam int unsigned SB_24HOUR_BIT = 1;
    localparam int unsigned HOUR_PM_BIT   = 7;

    localparam logic [7:0]  YEAR_PIVOT    = 8'd70;
    localparam logic [11:0] CENTURY_21    = 12'd2000;
    localparam logic [11:0] CENTURY_20    = 12'd1900;
    localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
    localparam logic [6:0]  EPOCH_MOD100  = 7'd70;
    localparam logic [8:0]  EPOCH_MOD400  = 9'd370;
    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;

    function automatic logic [7:0] from_bcd(input logic [7:0] v);
        return {4'b0000, v[3:0]} + 8'({4'b0000, v[7:4]} * 8'd10);
    endfunction

    // Remainder by twelve through a reciprocal; exact for 7-bit inputs.
    function automatic logic [3:0] mod12(input logic [6:0] v);
        logic [14:0] p;
        logic [6:0]  r;
        p = 15'(v) * 15'd171;
        r = v - 7'({3'b000, p[14:11]} * 7'd12);
        return r[3:0];
    endfunction

    function automatic logic [8:0] month_start(input logic [3:0] idx);
        logic [8:0] d;
        case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== sv/rtc_to_unix_timekeeper_top.sv =====
// Tick item: accepted when idle, counted in the tick state, then pushed as a beat.
// Load item: decode, then a year walk of one calendar year per cycle from 1970 to
// the sample's year, then days, mul, sum, push; a failed range check goes to push.
// One item in flight; the next is taken once the result sits in the output register.
// Synchronous active-low reset clears all counts and empties the output register.
`default_nettype none

`include "rtc_to_unix_timekeeper_top_assert.svh"

module rtc_to_unix_timekeeper_top #(
    parameter int unsigned TICKS_PER_SECOND = 100
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire rtut_pkg::t_in   i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output rtut_pkg::t_out       o_out_data
);

    rtut_pkg::t_cmd  w_cmd;
    rtut_pkg::t_stat w_stat;

    rtut_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_out_ready(i_out_ready),
        .o_out_valid(o_out_valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rtut_dp #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_data (i_in_data),
        .i_cmd     (w_cmd),
        .o_stat    (w_stat),
        .o_out_data(o_out_data)
    );

    `RTUT_ASSERT_IMPL(a_load_uptime_zero, o_out_valid && o_out_data.load_valid, o_out_data.uptime == 32'd0)
    `RTUT_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)
    `RTUT_ASSERT_NEXT(a_push_shows_beat, w_cmd.push, o_out_valid)
    `RTUT_ASSERT_IMPL(a_sum_only_when_ok, w_cmd.sum, w_stat.ok)

endmodule

`default_nettype wire

// ===== sv/rtut_ctrl.sv =====
// Controller state machine: sequences tick and load work and owns the beat handshakes.
`default_nettype none

module rtut_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire logic           i_out_ready,
    output logic                o_out_valid,
    input  wire rtut_pkg::t_stat i_stat,
    output rtut_pkg::t_cmd      o_cmd
);

    rtut_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             w_push_ok;

    assign w_push_ok = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            rtut_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.is_load ? rtut_pkg::S_DECODE : rtut_pkg::S_TICK;
                end
            end
            rtut_pkg::S_TICK:   n_state = rtut_pkg::S_PUSH;
            rtut_pkg::S_DECODE: n_state = rtut_pkg::S_YEAR;
            rtut_pkg::S_YEAR: begin
                if (!i_stat.ok) begin
                    n_state = rtut_pkg::S_PUSH;
                end else if (i_stat.year_done) begin
                    n_state = rtut_pkg::S_DAYS;
                end
            end
            rtut_pkg::S_DAYS: n_state = rtut_pkg::S_MUL;
            rtut_pkg::S_MUL:  n_state = rtut_pkg::S_SUM;
            rtut_pkg::S_SUM:  n_state = rtut_pkg::S_PUSH;
            rtut_pkg::S_PUSH: begin
                if (w_push_ok) begin
                    n_state = rtut_pkg::S_IDLE;
                end
            end
            default: n_state = rtut_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            rtut_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            rtut_pkg::S_TICK:   o_cmd.tick = 1'b1;
            rtut_pkg::S_DECODE: o_cmd.decode = 1'b1;
            rtut_pkg::S_YEAR:   o_cmd.year_step = i_stat.ok && !i_stat.year_done;
            rtut_pkg::S_DAYS:   o_cmd.add_days = 1'b1;
            rtut_pkg::S_MUL:    o_cmd.mul = 1'b1;
            rtut_pkg::S_SUM:    o_cmd.sum = 1'b1;
            rtut_pkg::S_PUSH:   o_cmd.push = w_push_ok;
            default:            o_cmd = '0;
        endcase
    end

    // Hold the result beat until taken; a push refills it in the same cycle.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.push) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rtut_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== sv/rtut_dp.sv =====
// Datapath: counters, RTC sample decode, year walk, seconds arithmetic and result register.
`default_nettype none

module rtut_dp #(
    parameter int unsigned TICKS_PER_SECOND = 100
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire rtut_pkg::t_in   i_in_data,
    input  wire rtut_pkg::t_cmd  i_cmd,
    output rtut_pkg::t_stat      o_stat,
    output rtut_pkg::t_out       o_out_data
);

    localparam int unsigned FracW = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
    localparam logic [FracW-1:0] FracLast = FracW'(TICKS_PER_SECOND - 1);

    rtut_pkg::t_in  r_raw;
    rtut_pkg::t_out r_out;

    logic [7:0]  r_sec, r_min, r_day, r_mon;
    logic [6:0]  r_hr;
    logic [11:0] r_yr;
    logic        r_read_ok;

    logic [11:0] r_year;
    logic [6:0]  r_c100;
    logic [8:0]  r_c400;
    logic [16:0] r_days;
    logic [31:0] r_prod;
    logic [16:0] r_hms;

    logic [31:0]      r_seconds, r_uptime;
    logic [FracW-1:0] r_frac;
    logic             r_load_valid;

    // Decode of the captured sample.
    logic        w_binary, w_24h;
    logic [7:0]  w_sec_bcd, w_min_bcd, w_day_bcd, w_mon_bcd, w_yr_bcd, w_hr_bcd;
    logic [7:0]  w_sec, w_min, w_day, w_mon, w_yr8, w_hr8;
    logic [6:0]  w_hr;
    logic [11:0] w_yr;
    logic        w_leap, w_range_ok;
    logic [3:0]  w_mon_idx;
    logic [16:0] w_leap_adj;
    logic [33:0] w_prod;

    assign w_binary  = r_raw.rtc_status[rtut_pkg::SB_BINARY_BIT];
    assign w_24h     = r_raw.rtc_status[rtut_pkg::SB_24HOUR_BIT];
    assign w_sec_bcd = rtut_pkg::from_bcd(r_raw.raw_seconds);
    assign w_min_bcd = rtut_pkg::from_bcd(r_raw.raw_minutes);
    assign w_day_bcd = rtut_pkg::from_bcd(r_raw.raw_day);
    assign w_mon_bcd = rtut_pkg::from_bcd(r_raw.raw_month);
    assign w_yr_bcd  = rtut_pkg::from_bcd(r_raw.raw_year);
    assign w_hr_bcd  = rtut_pkg::from_bcd({1'b0, r_raw.raw_hours[6:0]});

    assign w_sec = w_binary ? r_raw.raw_seconds : w_sec_bcd;
    assign w_min = w_binary ? r_raw.raw_minutes : w_min_bcd;
    assign w_day = w_binary ? r_raw.raw_day     : w_day_bcd;
    assign w_mon = w_binary ? r_raw.raw_month   : w_mon_bcd;
    assign w_yr8 = w_binary ? r_raw.raw_year    : w_yr_bcd;
    assign w_hr8 = w_binary ? r_raw.raw_hours
                            : {r_raw.raw_hours[rtut_pkg::HOUR_PM_BIT], w_hr_bcd[6:0]};

    // Fold 12-hour time with its PM flag into 24-hour time.
    always_comb begin
        if (w_24h) begin
            w_hr = w_hr8[6:0];
        end else begin
            w_hr = {3'b000, rtut_pkg::mod12(w_hr8[6:0])}
                 + (w_hr8[rtut_pkg::HOUR_PM_BIT] ? 7'd12 : 7'd0);
        end
    end

    assign w_yr = (w_yr8 < rtut_pkg::YEAR_PIVOT) ? (12'(w_yr8) + rtut_pkg::CENTURY_21)
                                                 : (12'(w_yr8) + rtut_pkg::CENTURY_20);

    assign w_range_ok = r_read_ok
                     && (r_mon >= 8'd1) && (r_mon <= 8'd12)
                     && (r_day >= 8'd1) && (r_day <= 8'd31)
                     && (r_hr <= 7'd23) && (r_min <= 8'd59) && (r_sec <= 8'd59);

    // Leap rule from running year residues.
    assign w_leap     = (r_year[1:0] == 2'b00) && ((r_c100 != 7'd0) || (r_c400 == 9'd0));
    assign w_mon_idx  = r_mon[3:0] - 4'd1;
    assign w_leap_adj = ((r_mon > 8'd2) && w_leap) ? 17'd1 : 17'd0;
    assign w_prod     = 34'(r_days) * 34'(rtut_pkg::SECS_PER_DAY);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_raw <= i_in_data;
        end
        if (i_cmd.decode) begin
            r_sec     <= w_sec;
            r_min     <= w_min;
            r_hr      <= w_hr;
            r_day     <= w_day;
            r_mon     <= w_mon;
            r_yr      <= w_yr;
            r_read_ok <= r_raw.read_ok;
            r_year    <= rtut_pkg::EPOCH_YEAR;
            r_c100    <= rtut_pkg::EPOCH_MOD100;
            r_c400    <= rtut_pkg::EPOCH_MOD400;
            r_days    <= '0;
        end
        if (i_cmd.year_step) begin
            r_days <= r_days + (w_leap ? 17'd366 : 17'd365);
            r_year <= r_year + 12'd1;
            r_c100 <= (r_c100 == 7'd99) ? 7'd0 : r_c100 + 7'd1;
            r_c400 <= (r_c400 == 9'd399) ? 9'd0 : r_c400 + 9'd1;
        end
        if (i_cmd.add_days) begin
            r_days <= r_days + 17'(rtut_pkg::month_start(w_mon_idx)) + w_leap_adj
                    + 17'(r_day) - 17'd1;
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod[31:0];
            r_hms  <= 17'(r_hr) * 17'd3600 + 17'(r_min) * 17'd60 + 17'(r_sec);
        end
        if (i_cmd.push) begin
            r_out <= '{unix_seconds: r_seconds, uptime: r_uptime, load_valid: r_load_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seconds    <= '0;
            r_uptime     <= '0;
            r_frac       <= '0;
            r_load_valid <= 1'b0;
        end else if (i_cmd.tick) begin
            r_uptime     <= r_uptime + 32'd1;
            r_load_valid <= 1'b0;
            if (r_frac == FracLast) begin
                r_frac    <= '0;
                r_seconds <= r_seconds + 32'd1;
            end else begin
                r_frac <= r_frac + FracW'(1);
            end
        end else if (i_cmd.decode) begin
            r_seconds    <= '0;
            r_uptime     <= '0;
            r_frac       <= '0;
            r_load_valid <= 1'b0;
        end else if (i_cmd.sum) begin
            r_seconds    <= r_prod + 32'(r_hms);
            r_load_valid <= 1'b1;
        end
    end

    assign o_stat.is_load   = i_in_data.cmd;
    assign o_stat.ok        = w_range_ok;
    assign o_stat.year_done = (r_year == r_yr);
    assign o_out_data       = r_out;

endmodule

`default_nettype wire
